/* design/md5_message_digest_core_assert.svh */
// Assertion macros for the MD5 core modules, used by md5_back.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MD5_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define MD5_CHECK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 core check failed");

`define MD5_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 core check failed");

`else

`define MD5_CHECK_SAME(label, ante, cons)

`define MD5_CHECK_NEXT(label, ante, cons)

`endif

`endif

/* design/md5_pkg.sv */
package md5_pkg;

    typedef logic [15:0][31:0] block_t;

    // One block handed from the packer to the compression engine.
    typedef struct packed {
        block_t words;
        logic   is_final;
    } blk_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;

    localparam logic [3:0] MSG_FIRST [4] = '{4'd0, 4'd1, 4'd5, 4'd0};
    localparam logic [3:0] MSG_STRIDE [4] = '{4'd1, 4'd5, 4'd3, 4'd7};

    localparam logic [4:0] ROT_AMT [4][4] = '{
        '{5'd7, 5'd12, 5'd17, 5'd22},
        '{5'd5, 5'd9,  5'd14, 5'd20},
        '{5'd4, 5'd11, 5'd16, 5'd23},
        '{5'd6, 5'd10, 5'd15, 5'd21}
    };

    localparam logic [31:0] K_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Nonlinear function of the round group.
    function automatic logic [31:0] mix(
        input logic [1:0]  grp,
        input logic [31:0] x,
        input logic [31:0] y,
        input logic [31:0] z
    );
        logic [31:0] r;
        case (grp)
            2'd0:    r = (x & y) | (~x & z);
            2'd1:    r = (x & z) | (y & ~z);
            2'd2:    r = x ^ y ^ z;
            default: r = y ^ (x | ~z);
        endcase
        return r;
    endfunction

    // Message word used by a round.
    function automatic logic [3:0] word_sel(input logic [5:0] idx);
        logic [3:0] prod;
        prod = 4'(MSG_STRIDE[idx[5:4]] * idx[3:0]);
        return prod + MSG_FIRST[idx[5:4]];
    endfunction

    function automatic logic [4:0] rot_sel(input logic [5:0] idx);
        return ROT_AMT[idx[5:4]][idx[1:0]];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

/* design/md5_if.sv */
interface md5_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_item;

    modport source (output valid, output data_byte, output byte_valid, output last_item,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid, input last_item,
                  output ready);
endinterface

interface md5_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink (input valid, input digest_low, input digest_high, output ready);
endinterface

/* design/md5_front.sv */
module md5_front (
    input  logic                  clk,
    input  logic                  rst_n,
    md5_byte_if.sink              msg,
    input  md5_pkg::q_status_t    q_status,
    output logic                  push,
    output md5_pkg::blk_entry_t   push_entry
);

    typedef enum logic [2:0] {
        F_TAKE = 3'b001,
        F_PAD  = 3'b010,
        F_LEN  = 3'b100
    } front_state_t;

    front_state_t      state_reg, state_next;
    logic [5:0]        pos_reg, pos_next;
    logic [63:0]       len_reg, len_next;
    logic [63:0][7:0]  buf_reg, buf_next;
    logic [63:0][7:0]  pad_bytes;
    logic              accept;

    assign msg.ready = (state_reg == F_TAKE) && !q_status.full;
    assign accept    = msg.valid && msg.ready;

    // Tail block: kept bytes, the pad marker, zeros, and the length when it fits; in F_LEN, zeros and the length.
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            if (state_reg == F_LEN)
                pad_bytes[i] = 8'h00;
            else if (6'(i) < pos_reg)
                pad_bytes[i] = buf_reg[i];
            else if (6'(i) == pos_reg)
                pad_bytes[i] = md5_pkg::PAD_BYTE;
            else
                pad_bytes[i] = 8'h00;
        end
        if (state_reg == F_LEN || pos_reg < md5_pkg::LEN_START)
        begin
            for (int k = 0; k < 8; k++)
                pad_bytes[56 + k] = len_reg[8 * k +: 8];
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        pos_next            = pos_reg;
        len_next            = len_reg;
        buf_next            = buf_reg;
        push                = 1'b0;
        push_entry.words    = pad_bytes;
        push_entry.is_final = 1'b0;
        case (state_reg)
            F_TAKE:
            begin
                if (accept)
                begin
                    if (msg.byte_valid)
                    begin
                        buf_next[pos_reg] = msg.data_byte;
                        pos_next          = pos_reg + 6'd1;
                        len_next          = len_reg + 64'd8;
                        push_entry.words  = buf_next;
                        push              = (pos_reg == md5_pkg::LAST_SLOT);
                    end
                    if (msg.last_item)
                        state_next = F_PAD;
                end
            end
            F_PAD:
            begin
                if (!q_status.full)
                begin
                    push = 1'b1;
                    if (pos_reg < md5_pkg::LEN_START)
                    begin
                        push_entry.is_final = 1'b1;
                        pos_next            = '0;
                        len_next            = '0;
                        state_next          = F_TAKE;
                    end
                    else
                    begin
                        state_next = F_LEN;
                    end
                end
            end
            F_LEN:
            begin
                if (!q_status.full)
                begin
                    push                = 1'b1;
                    push_entry.is_final = 1'b1;
                    pos_next            = '0;
                    len_next            = '0;
                    state_next          = F_TAKE;
                end
            end
            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_TAKE;
            pos_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

/* design/md5_block_queue.sv */
module md5_block_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  md5_pkg::blk_entry_t  push_entry,
    input  logic                 pop,
    output md5_pkg::blk_entry_t  head,
    output md5_pkg::q_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    md5_pkg::blk_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* design/md5_back.sv */
`include "md5_message_digest_core_assert.svh"

module md5_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  md5_pkg::blk_entry_t  head,
    input  md5_pkg::q_status_t   q_status,
    output logic                 pop,
    md5_digest_if.source         digest
);

    typedef enum logic [2:0] {
        B_IDLE   = 3'b001,
        B_ROUND  = 3'b010,
        B_FINISH = 3'b100
    } back_state_t;

    back_state_t     state_reg;
    logic [5:0]      round_idx_reg;
    logic [5:0]      idx_next;
    md5_pkg::block_t blk_reg;
    logic            final_reg;
    logic [31:0]     rw_reg [4];
    logic [31:0]     chain_reg [4];
    logic [31:0]     sum [4];
    logic [31:0]     km_reg, km_next;
    logic [31:0]     t_word, nb_word;
    logic            out_valid_reg;
    logic [63:0]     out_low_reg, out_high_reg;
    logic            out_free;
    logic            finish_fire;

    assign pop         = (state_reg == B_IDLE) && !q_status.empty;
    assign idx_next    = round_idx_reg + 6'd1;
    assign out_free    = !out_valid_reg || digest.ready;
    assign finish_fire = (state_reg == B_FINISH) && (!final_reg || out_free);

    // The constant plus message word is fetched one round ahead.
    always_comb
    begin
        if (state_reg == B_IDLE)
            km_next = md5_pkg::K_ADD[0] + head.words[md5_pkg::word_sel(6'd0)];
        else
            km_next = md5_pkg::K_ADD[idx_next] + blk_reg[md5_pkg::word_sel(idx_next)];
    end

    assign t_word  = rw_reg[0] + md5_pkg::mix(round_idx_reg[5:4], rw_reg[1], rw_reg[2], rw_reg[3])
                     + km_reg;
    assign nb_word = rw_reg[1] + md5_pkg::rotl(t_word, md5_pkg::rot_sel(round_idx_reg));

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            sum[i] = chain_reg[i] + rw_reg[i];
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_low  = out_low_reg;
    assign digest.digest_high = out_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            round_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                chain_reg[i] <= md5_pkg::CHAIN_INIT[i];
        end
        else
        begin
            if (digest.valid && digest.ready && !(finish_fire && final_reg))
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg     <= B_ROUND;
                        round_idx_reg <= '0;
                    end
                end
                B_ROUND:
                begin
                    round_idx_reg <= idx_next;
                    if (round_idx_reg == md5_pkg::LAST_SLOT)
                        state_reg <= B_FINISH;
                end
                B_FINISH:
                begin
                    if (finish_fire)
                    begin
                        state_reg <= B_IDLE;
                        for (int i = 0; i < 4; i++)
                            chain_reg[i] <= final_reg ? md5_pkg::CHAIN_INIT[i] : sum[i];
                        if (final_reg)
                            out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        km_reg <= km_next;
        if (pop)
        begin
            blk_reg   <= head.words;
            final_reg <= head.is_final;
            for (int i = 0; i < 4; i++)
                rw_reg[i] <= chain_reg[i];
        end
        else if (state_reg == B_ROUND)
        begin
            rw_reg[0] <= rw_reg[3];
            rw_reg[3] <= rw_reg[2];
            rw_reg[2] <= rw_reg[1];
            rw_reg[1] <= nb_word;
        end
        if (finish_fire && final_reg)
        begin
            out_low_reg  <= {sum[1], sum[0]};
            out_high_reg <= {sum[3], sum[2]};
        end
    end

    `MD5_CHECK_NEXT(a_last_round_finishes, state_reg == B_ROUND && round_idx_reg == md5_pkg::LAST_SLOT, state_reg == B_FINISH)
    `MD5_CHECK_NEXT(a_load_seeds_rounds, pop, state_reg == B_ROUND && round_idx_reg == 6'd0 && rw_reg[1] == chain_reg[1])
    `MD5_CHECK_NEXT(a_digest_restarts_chain, finish_fire && final_reg, out_valid_reg && chain_reg[0] == md5_pkg::CHAIN_INIT[0])

endmodule

/* design/md5_message_digest_core.sv */
// MD5 hash engine with a byte-wide message channel and a 128-bit digest channel.
// Channel msg carries one beat per item: data_byte with byte_valid set when it holds
// a message byte, and last_item set on the beat that ends the message. A beat with
// byte_valid low and last_item high ends the message without a byte, so the empty
// message is hashed too. Channel digest returns one beat per message: digest_low holds
// digest bytes 0 to 7 and digest_high bytes 8 to 15, byte 0 in bits 7 to 0.
// The front packs bytes into a 64-byte block and pads the message tail; each full or
// padded block goes into a block queue of QUEUE_DEPTH entries. The back compresses one
// block by a load, 64 rounds at one round per cycle and a chaining update, and pops a
// new block only once it is done with the last. Bytes are taken one per cycle until the
// queue fills; sustained, the round loop of the back sets the rate. After the last beat
// the front builds the tail blocks in F_PAD and, when the length does not fit, F_LEN,
// waiting while the queue is full, and msg.ready is low meanwhile.
// Reset clears the queue, the byte count and length, and loads the initial
// chaining value; no clearing pass is needed. When the digest receiver stalls, the
// digest is held in the output register and the back waits at the end of the next
// final block, while the queue and then msg.ready apply backpressure upstream.
module md5_message_digest_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    md5_byte_if.sink      msg,
    md5_digest_if.source  digest
);

    md5_pkg::blk_entry_t push_entry;
    md5_pkg::blk_entry_t head;
    md5_pkg::q_status_t  q_status;
    logic                push;
    logic                pop;

    md5_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    md5_block_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    md5_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .digest   (digest)
    );

endmodule

/* tb/sv/md5_digest_checker.sv */
module md5_digest_checker (
    input  logic   clk,
    input  logic   rst_n,
    md5_byte_if    msg_mon,
    md5_digest_if  dig_mon,
    output int     fail_count,
    output int     digests_open
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } digest_pair_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] CHAIN_SEED [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    // Per-round shift amounts, four per round group.
    localparam int SHIFTS [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    digest_pair_t expected_digests [$];
    logic [31:0]  msg_words [16];
    logic [31:0]  hash_state [4];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_pos;

    function automatic void put_byte(input int pos, input logic [7:0] value);
        msg_words[pos / 4][(pos % 4) * 8 +: 8] = value;
    endfunction

    // One 64-round pass over the current block, folded into the chaining words.
    function automatic void compress_words();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] f;
        logic [31:0] t;
        int          g;
        int          j;
        int          w;
        int          s;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int r = 0; r < 64; r++)
        begin
            g = r / 16;
            j = r % 16;
            case (g)
                0:
                begin
                    f = (b & c) | (~b & d);
                    w = j;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    w = (1 + 5 * j) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    w = (5 + 3 * j) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    w = (7 * j) % 16;
                end
            endcase
            s = SHIFTS[g * 4 + (r % 4)];
            t = a + f + msg_words[w] + ROUND_ADD[r];
            t = (t << s) | (t >> (32 - s));
            a = d;
            d = c;
            c = b;
            b = b + t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 4; i++)
        begin
            hash_state[i] = CHAIN_SEED[i];
        end
        msg_bits = '0;
        fill_pos = '0;
    endfunction

    // Absorbs one accepted beat; a beat that ends the message queues its digest.
    function automatic void absorb_beat(input logic [7:0] data, input logic has_byte,
                                        input logic ends_msg);
        int pos;
        if (has_byte)
        begin
            put_byte(fill_pos, data);
            msg_bits = msg_bits + 64'd8;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == 6'd0)
            begin
                compress_words();
            end
        end
        if (ends_msg)
        begin
            pos = fill_pos;
            put_byte(pos, PAD_MARK);
            pos++;
            // Too little room for the length: this block closes with zeros.
            if (pos > 56)
            begin
                for (; pos < 64; pos++)
                begin
                    put_byte(pos, 8'h00);
                end
                compress_words();
                pos = 0;
            end
            for (; pos < 56; pos++)
            begin
                put_byte(pos, 8'h00);
            end
            msg_words[14] = msg_bits[31:0];
            msg_words[15] = msg_bits[63:32];
            compress_words();
            expected_digests.push_back('{low: {hash_state[1], hash_state[0]},
                                         high: {hash_state[3], hash_state[2]}});
            restart_message();
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_digests.delete();
            for (int i = 0; i < 16; i++)
            begin
                msg_words[i] = '0;
            end
            restart_message();
            fail_count = 0;
        end
        else
        begin
            if (dig_mon.valid && dig_mon.ready)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("digest: unexpected beat, low %h high %h",
                           dig_mon.digest_low, dig_mon.digest_high);
                    fail_count++;
                end
                else
                begin
                    if (dig_mon.digest_low !== expected_digests[0].low)
                    begin
                        $error("digest_low: expected %h, got %h",
                               expected_digests[0].low, dig_mon.digest_low);
                        fail_count++;
                    end
                    if (dig_mon.digest_high !== expected_digests[0].high)
                    begin
                        $error("digest_high: expected %h, got %h",
                               expected_digests[0].high, dig_mon.digest_high);
                        fail_count++;
                    end
                    void'(expected_digests.pop_front());
                end
            end
            if (msg_mon.valid && msg_mon.ready)
            begin
                absorb_beat(msg_mon.data_byte, msg_mon.byte_valid, msg_mon.last_item);
            end
        end
        digests_open = expected_digests.size();
    end

endmodule

/* tb/sv/tb_md5_message_digest_core.sv */
module tb_md5_message_digest_core;
    timeunit 1ns;
    timeprecision 1ps;

    // The random part stops once both of these are reached.
    localparam int TARGET_BEATS    = 550;
    localparam int TARGET_MESSAGES = 20;

    // The one long digest stall starts after this many digests have been taken.
    localparam int HOLD_AFTER  = 6;
    localparam int HOLD_CYCLES = 700;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int digests_open;

    // Counters for the stimulus: data beats exclude the beats that carry
    // neither a byte nor an end, since the block just drops those.
    int data_beats;
    int messages_sent;

    // Remaining length of a no-idle stretch, one per channel side.
    int msg_calm;
    int dig_calm;

    md5_byte_if   msg_ch ();
    md5_digest_if digest_ch ();

    md5_message_digest_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    // The checker sits beside the block, predicts every digest from the
    // accepted message beats and counts mismatches.
    md5_digest_checker watcher (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_mon      (msg_ch),
        .dig_mon      (digest_ch),
        .fail_count   (fail_count),
        .digests_open (digests_open)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle cycles before the next beat. Now and then a stretch of beats runs
    // back to back so that the block also sees full-rate traffic.
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Offers one message beat and waits until the block takes it. The valid
    // line stays high when no idle gap is drawn, so back-to-back beats never
    // lower and raise it in the same step.
    task automatic send_beat(input logic [7:0] data, input logic has_byte,
                             input logic ends_msg);
        int gap;
        gap = draw_gap(msg_calm);
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_byte  <= data;
        msg_ch.byte_valid <= has_byte;
        msg_ch.last_item  <= ends_msg;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        if (has_byte || ends_msg)
        begin
            data_beats++;
        end
        if (ends_msg)
        begin
            messages_sent++;
        end
    endtask

    // A message of random bytes. The end either rides on the final byte or
    // comes as a beat of its own; ignored beats are sprinkled in between.
    task automatic send_message(input int len, input logic end_apart);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_beat(8'($urandom), 1'b0, 1'b0);
            end
            send_beat(8'($urandom), 1'b1, (i == len - 1) && !end_apart);
        end
        if (len == 0 || end_apart)
        begin
            send_beat(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Message side: reset, a short directed opening, then random messages.
    initial
    begin
        int len;
        rst_n             <= 1'b0;
        msg_ch.valid      <= 1'b0;
        msg_ch.data_byte  <= '0;
        msg_ch.byte_valid <= 1'b0;
        msg_ch.last_item  <= 1'b0;
        data_beats    = 0;
        messages_sent = 0;
        msg_calm      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A beat with neither byte nor end must leave no trace.
        send_beat(8'hFF, 1'b0, 1'b0);
        // The empty message: an end with no byte at all.
        send_beat(8'h00, 1'b0, 1'b1);
        // One byte carrying the end as well, at the top of the byte range.
        send_beat(8'hFF, 1'b1, 1'b1);
        // The classic three-byte message.
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        // A zero byte followed by a bare end beat.
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
        // Mixed extremes with ignored beats inside the message.
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b1);

        // Most messages are short to keep digests frequent. The rest sit at
        // the block boundaries: a pad that just fits beside the length, one
        // that spills into a further block, a block filled by the final byte,
        // and messages spanning two blocks.
        while (data_beats < TARGET_BEATS || messages_sent < TARGET_MESSAGES)
        begin
            case ($urandom_range(0, 15))
                0:       len = $urandom_range(0, 2);
                1:       len = $urandom_range(54, 57);
                2:       len = $urandom_range(62, 65);
                3:       len = $urandom_range(119, 121);
                default: len = $urandom_range(1, 12);
            endcase
            send_message(len, $urandom_range(0, 3) == 0);
        end
        msg_ch.valid <= 1'b0;

        // Let the checker see the final beat, drain the outstanding digests,
        // then give any stray beat time to show up.
        @(posedge clk);
        while (digests_open != 0) @(posedge clk);
        repeat (250) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** md5_message_digest_core: PASSED **");
        end
        else
        begin
            $display("** md5_message_digest_core: FAILED **");
        end
        $finish;
    end

    // Digest side: random stalls before each beat. Once, the receiver holds
    // off for a long stretch while messages keep coming, so the block queue
    // fills and the message channel has to stall.
    initial
    begin
        int gap;
        int beats_taken;
        digest_ch.ready <= 1'b0;
        beats_taken = 0;
        dig_calm    = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(dig_calm);
            if (beats_taken == HOLD_AFTER)
            begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                digest_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            digest_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!digest_ch.valid);
            beats_taken++;
        end
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #10000000;
        $display("** md5_message_digest_core: FAILED **");
        $finish;
    end

endmodule
